// ===== rtl/erm_pkg.sv =====
// ----------------------------------------------------------------------------
// erm_pkg
// Shared widths, constants and helpers for the Euler angle to rotation
// matrix block.
// ----------------------------------------------------------------------------
package erm_pkg;

  localparam int ANGLE_WIDTH = 16;
  localparam int COEF_WIDTH  = 16;
  localparam int TRIG_STAGES = 14;

  localparam int ANG_FRAC  = ANGLE_WIDTH - 3;
  localparam int OUT_FRAC  = COEF_WIDTH - 2;
  localparam int ANG_SHIFT = 30 - ANG_FRAC;

  // CORDIC working width (Q30 angle up to +-2^32 before clamp)
  localparam int WORK_W = 34;
  // sine / cosine width, Q30
  localparam int TRIG_W = 32;
  // full product width, Q60
  localparam int Q60_W  = 64;

  localparam logic signed [WORK_W-1:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [WORK_W-1:0] NEG_PI_Q30  = -PI_Q30;
  localparam logic signed [WORK_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [WORK_W-1:0] NEG_HALF_PI = -HALF_PI_Q30;
  localparam logic signed [WORK_W-1:0] GAIN_Q30    = 34'sd652032874;

  localparam logic signed [31:0] ATAN_Q30 [0:29] = '{
    32'sd843314857, 32'sd497837829, 32'sd263043836, 32'sd133525158,
    32'sd67021686,  32'sd33543515,  32'sd16775850,  32'sd8388437,
    32'sd4194282,   32'sd2097149,   32'sd1048575,   32'sd524287,
    32'sd262143,    32'sd131071,    32'sd65535,     32'sd32767,
    32'sd16383,     32'sd8191,      32'sd4095,      32'sd2047,
    32'sd1023,      32'sd511,       32'sd255,       32'sd127,
    32'sd63,        32'sd31,        32'sd15,        32'sd8,
    32'sd4,         32'sd2
  };

  localparam logic signed [Q60_W-1:0] HALF_Q30 = 64'sd1 <<< 29;

  localparam int RND_SHIFT = 60 - OUT_FRAC;
  localparam logic signed [Q60_W-1:0] RND_HALF = 64'sd1 <<< (RND_SHIFT - 1);
  localparam logic signed [Q60_W-1:0] OUT_LIM  = 64'sd1 <<< OUT_FRAC;
  localparam logic signed [Q60_W-1:0] OUT_NLIM = -OUT_LIM;

  // clamp, fold, CORDIC stages, sign fix
  localparam int LANE_LAT  = TRIG_STAGES + 3;
  localparam int MERGE_LAT = 5;
  localparam int LATENCY   = LANE_LAT + MERGE_LAT;

  typedef struct packed {
    logic signed [TRIG_W-1:0] sin_v;
    logic signed [TRIG_W-1:0] cos_v;
  } trig_t;

  typedef logic [8:0][COEF_WIDTH-1:0] matrix_t;

  // Q60 to output format: round half up, floor shift, saturate at +-1
  function automatic logic [COEF_WIDTH-1:0] q60_round(input logic signed [Q60_W-1:0] v);
    logic signed [Q60_W-1:0] r;
    r = (v + RND_HALF) >>> RND_SHIFT;
    if (r > OUT_LIM) begin
      r = OUT_LIM;
    end else if (r < OUT_NLIM) begin
      r = OUT_NLIM;
    end
    return r[COEF_WIDTH-1:0];
  endfunction

endpackage

// ===== rtl/erm_cordic.sv =====
// ----------------------------------------------------------------------------
// erm_cordic
// One trig lane: clamps and folds an angle, then a pipelined rotation-mode
// CORDIC gives its sine and cosine in Q30.
// ----------------------------------------------------------------------------
module erm_cordic (
  input  logic                                      clk,
  input  logic signed [erm_pkg::ANGLE_WIDTH-1:0]    angle,
  output erm_pkg::trig_t                            trig
);

  localparam int S = erm_pkg::TRIG_STAGES;
  localparam int W = erm_pkg::WORK_W;

  logic signed [W-1:0] ang_ext;
  logic signed [W-1:0] clamp_nxt;
  logic signed [W-1:0] clamp_r;
  logic signed [W-1:0] fold_nxt;
  logic                flip_nxt;

  logic signed [W-1:0] xs_r [0:S];
  logic signed [W-1:0] ys_r [0:S];
  logic signed [W-1:0] zs_r [0:S-1];
  logic                fl_r [0:S];

  erm_pkg::trig_t trig_r;

  assign ang_ext = W'(angle) <<< erm_pkg::ANG_SHIFT;

  always_comb begin
    if (ang_ext > erm_pkg::PI_Q30) begin
      clamp_nxt = erm_pkg::PI_Q30;
    end else if (ang_ext < erm_pkg::NEG_PI_Q30) begin
      clamp_nxt = erm_pkg::NEG_PI_Q30;
    end else begin
      clamp_nxt = ang_ext;
    end
  end

  always_comb begin
    if (clamp_r > erm_pkg::HALF_PI_Q30) begin
      fold_nxt = clamp_r - erm_pkg::PI_Q30;
      flip_nxt = 1'b1;
    end else if (clamp_r < erm_pkg::NEG_HALF_PI) begin
      fold_nxt = clamp_r + erm_pkg::PI_Q30;
      flip_nxt = 1'b1;
    end else begin
      fold_nxt = clamp_r;
      flip_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    clamp_r  <= clamp_nxt;
    xs_r[0]  <= erm_pkg::GAIN_Q30;
    ys_r[0]  <= '0;
    zs_r[0]  <= fold_nxt;
    fl_r[0]  <= flip_nxt;
  end

  for (genvar i = 0; i < S; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (!zs_r[i][W-1]) begin
        xs_r[i+1] <= xs_r[i] - (ys_r[i] >>> i);
        ys_r[i+1] <= ys_r[i] + (xs_r[i] >>> i);
      end else begin
        xs_r[i+1] <= xs_r[i] + (ys_r[i] >>> i);
        ys_r[i+1] <= ys_r[i] - (xs_r[i] >>> i);
      end
      fl_r[i+1] <= fl_r[i];
    end

    if (i < S - 1) begin : g_z
      always_ff @(posedge clk) begin
        if (!zs_r[i][W-1]) begin
          zs_r[i+1] <= zs_r[i] - W'(erm_pkg::ATAN_Q30[i]);
        end else begin
          zs_r[i+1] <= zs_r[i] + W'(erm_pkg::ATAN_Q30[i]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fl_r[S]) begin
      trig_r.sin_v <= erm_pkg::TRIG_W'(-ys_r[S]);
      trig_r.cos_v <= erm_pkg::TRIG_W'(-xs_r[S]);
    end else begin
      trig_r.sin_v <= erm_pkg::TRIG_W'(ys_r[S]);
      trig_r.cos_v <= erm_pkg::TRIG_W'(xs_r[S]);
    end
  end

  assign trig = trig_r;

endmodule

// ===== rtl/erm_merge.sv =====
// ----------------------------------------------------------------------------
// erm_merge
// Combines the three lanes' sine and cosine into the nine ZYX matrix
// entries: products, Q30 rounding of the pitch terms, sums, output rounding.
// ----------------------------------------------------------------------------
module erm_merge (
  input  logic             clk,
  input  erm_pkg::trig_t   roll,
  input  erm_pkg::trig_t   pitch,
  input  erm_pkg::trig_t   yaw,
  output erm_pkg::matrix_t mat
);

  localparam int PW = erm_pkg::Q60_W;
  localparam int TW = erm_pkg::TRIG_W;

  // stage 1: first products
  logic signed [PW-1:0] sps_p_r, spc_p_r;
  logic signed [PW-1:0] e0_1_r, e3_1_r, e6_1_r, e7_1_r, e8_1_r;
  logic signed [PW-1:0] t1_1_r, t2_1_r, t4_1_r, t5_1_r;
  logic signed [TW-1:0] cy_1_r, sy_1_r;

  // stage 2: pitch terms back to Q30
  logic signed [PW-1:0] sps_sum, spc_sum;
  logic signed [TW-1:0] sps_r, spc_r;
  logic signed [PW-1:0] e0_2_r, e3_2_r, e6_2_r, e7_2_r, e8_2_r;
  logic signed [PW-1:0] t1_2_r, t2_2_r, t4_2_r, t5_2_r;
  logic signed [TW-1:0] cy_2_r, sy_2_r;

  // stage 3: second products
  logic signed [PW-1:0] p1_r, p2_r, p4_r, p5_r;
  logic signed [PW-1:0] e0_3_r, e3_3_r, e6_3_r, e7_3_r, e8_3_r;
  logic signed [PW-1:0] t1_3_r, t2_3_r, t4_3_r, t5_3_r;

  // stage 4: exact Q60 entries
  logic signed [PW-1:0] q60_r [0:8];

  // stage 5: rounded entries
  erm_pkg::matrix_t mat_r;

  always_ff @(posedge clk) begin
    sps_p_r <= PW'(pitch.sin_v) * PW'(roll.sin_v);
    spc_p_r <= PW'(pitch.sin_v) * PW'(roll.cos_v);
    e0_1_r  <= PW'(yaw.cos_v) * PW'(pitch.cos_v);
    e3_1_r  <= PW'(yaw.sin_v) * PW'(pitch.cos_v);
    e6_1_r  <= -(PW'(pitch.sin_v)) <<< 30;
    e7_1_r  <= PW'(pitch.cos_v) * PW'(roll.sin_v);
    e8_1_r  <= PW'(pitch.cos_v) * PW'(roll.cos_v);
    t1_1_r  <= PW'(yaw.sin_v) * PW'(roll.cos_v);
    t2_1_r  <= PW'(yaw.sin_v) * PW'(roll.sin_v);
    t4_1_r  <= PW'(yaw.cos_v) * PW'(roll.cos_v);
    t5_1_r  <= PW'(yaw.cos_v) * PW'(roll.sin_v);
    cy_1_r  <= yaw.cos_v;
    sy_1_r  <= yaw.sin_v;
  end

  assign sps_sum = (sps_p_r + erm_pkg::HALF_Q30) >>> 30;
  assign spc_sum = (spc_p_r + erm_pkg::HALF_Q30) >>> 30;

  always_ff @(posedge clk) begin
    sps_r  <= sps_sum[TW-1:0];
    spc_r  <= spc_sum[TW-1:0];
    e0_2_r <= e0_1_r;
    e3_2_r <= e3_1_r;
    e6_2_r <= e6_1_r;
    e7_2_r <= e7_1_r;
    e8_2_r <= e8_1_r;
    t1_2_r <= t1_1_r;
    t2_2_r <= t2_1_r;
    t4_2_r <= t4_1_r;
    t5_2_r <= t5_1_r;
    cy_2_r <= cy_1_r;
    sy_2_r <= sy_1_r;
  end

  always_ff @(posedge clk) begin
    p1_r   <= PW'(cy_2_r) * PW'(sps_r);
    p2_r   <= PW'(cy_2_r) * PW'(spc_r);
    p4_r   <= PW'(sy_2_r) * PW'(sps_r);
    p5_r   <= PW'(sy_2_r) * PW'(spc_r);
    e0_3_r <= e0_2_r;
    e3_3_r <= e3_2_r;
    e6_3_r <= e6_2_r;
    e7_3_r <= e7_2_r;
    e8_3_r <= e8_2_r;
    t1_3_r <= t1_2_r;
    t2_3_r <= t2_2_r;
    t4_3_r <= t4_2_r;
    t5_3_r <= t5_2_r;
  end

  always_ff @(posedge clk) begin
    q60_r[0] <= e0_3_r;
    q60_r[1] <= p1_r - t1_3_r;
    q60_r[2] <= p2_r + t2_3_r;
    q60_r[3] <= e3_3_r;
    q60_r[4] <= p4_r + t4_3_r;
    q60_r[5] <= p5_r - t5_3_r;
    q60_r[6] <= e6_3_r;
    q60_r[7] <= e7_3_r;
    q60_r[8] <= e8_3_r;
  end

  for (genvar k = 0; k < 9; k++) begin : g_round
    always_ff @(posedge clk) begin
      mat_r[k] <= erm_pkg::q60_round(q60_r[k]);
    end
  end

  assign mat = mat_r;

endmodule

// ===== rtl/euler_to_rotation_matrix.sv =====
// ----------------------------------------------------------------------------
// euler_to_rotation_matrix
// ZYX Euler angles (Q3.13 radians) to the nine entries of Rz*Ry*Rx (Q1.14).
//
//   channel   ports                          handshake
//   request   in_roll/pitch/yaw_angle        start && !busy
//   result    out_rowN_colM (9 entries)      out_valid, one cycle
//
// One request per cycle; busy is held low. Three CORDIC lanes of
// TRIG_STAGES + 3 stages run side by side, then five merge stages of
// multiply, round and sum. Reset clears only the valid pipeline;
// results cannot be stalled.
// ----------------------------------------------------------------------------
module euler_to_rotation_matrix (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  logic signed [erm_pkg::ANGLE_WIDTH-1:0] in_roll_angle,
  input  logic signed [erm_pkg::ANGLE_WIDTH-1:0] in_pitch_angle,
  input  logic signed [erm_pkg::ANGLE_WIDTH-1:0] in_yaw_angle,
  output logic                                   out_valid,
  output logic signed [erm_pkg::COEF_WIDTH-1:0]  out_row0_col0,
  output logic signed [erm_pkg::COEF_WIDTH-1:0]  out_row0_col1,
  output logic signed [erm_pkg::COEF_WIDTH-1:0]  out_row0_col2,
  output logic signed [erm_pkg::COEF_WIDTH-1:0]  out_row1_col0,
  output logic signed [erm_pkg::COEF_WIDTH-1:0]  out_row1_col1,
  output logic signed [erm_pkg::COEF_WIDTH-1:0]  out_row1_col2,
  output logic signed [erm_pkg::COEF_WIDTH-1:0]  out_row2_col0,
  output logic signed [erm_pkg::COEF_WIDTH-1:0]  out_row2_col1,
  output logic signed [erm_pkg::COEF_WIDTH-1:0]  out_row2_col2
);

  localparam int LAT = erm_pkg::LATENCY;

  erm_pkg::trig_t   roll_trig, pitch_trig, yaw_trig;
  erm_pkg::matrix_t mat;

  logic [LAT-1:0] vld_r;
  logic [LAT-1:0] vld_nxt;

  assign busy = 1'b0;

  erm_cordic u_roll (
    .clk   (clk),
    .angle (in_roll_angle),
    .trig  (roll_trig)
  );

  erm_cordic u_pitch (
    .clk   (clk),
    .angle (in_pitch_angle),
    .trig  (pitch_trig)
  );

  erm_cordic u_yaw (
    .clk   (clk),
    .angle (in_yaw_angle),
    .trig  (yaw_trig)
  );

  erm_merge u_merge (
    .clk   (clk),
    .roll  (roll_trig),
    .pitch (pitch_trig),
    .yaw   (yaw_trig),
    .mat   (mat)
  );

  assign vld_nxt = {vld_r[LAT-2:0], start & ~busy};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign out_valid     = vld_r[LAT-1];
  assign out_row0_col0 = mat[0];
  assign out_row0_col1 = mat[1];
  assign out_row0_col2 = mat[2];
  assign out_row1_col0 = mat[3];
  assign out_row1_col1 = mat[4];
  assign out_row1_col2 = mat[5];
  assign out_row2_col0 = mat[6];
  assign out_row2_col1 = mat[7];
  assign out_row2_col2 = mat[8];

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for euler_to_rotation_matrix. It sends corner and
// random pose requests and checks every matrix entry against a bit-exact
// fixed-point CORDIC, product and rounding predictor.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int AW           = erm_pkg::ANGLE_WIDTH;
  localparam int CW           = erm_pkg::COEF_WIDTH;
  localparam int FRAC_OUT     = CW - 2;
  localparam int N_POSES      = 1000;
  localparam int WDOG_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 2 * erm_pkg::LATENCY + 8;

  localparam longint K_PI      = 64'sd3373259426;
  localparam longint K_HALF_PI = 64'sd1686629713;
  localparam longint K_GAIN    = 64'sd652032874;
  localparam int     N_ATAN    = 30;
  localparam longint CORDIC_ATAN [N_ATAN] = '{
    843314857, 497837829, 263043836, 133525158, 67021686, 33543515,
    16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071,
    65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127, 63, 31,
    15, 8, 4, 2
  };

  // angle codes: pi and the two codes either side of pi/2
  localparam int A_PI      = 25736;
  localparam int A_HALF_HI = 12868;
  localparam int A_HALF_LO = 12867;

  typedef logic signed [AW-1:0] angle_t;
  typedef logic signed [CW-1:0] coef_t;
  typedef logic [8:0][CW-1:0]   coef_mat_t;
  typedef struct packed {
    angle_t roll;
    angle_t pitch;
    angle_t yaw;
  } pose_t;

  logic   clk = 1'b0;
  logic   rst_n = 1'b0;
  logic   start = 1'b0;
  angle_t in_roll_angle = '0;
  angle_t in_pitch_angle = '0;
  angle_t in_yaw_angle = '0;
  logic   busy;
  logic   out_valid;
  coef_t  out_row0_col0, out_row0_col1, out_row0_col2;
  coef_t  out_row1_col0, out_row1_col1, out_row1_col2;
  coef_t  out_row2_col0, out_row2_col1, out_row2_col2;

  pose_t     pending_poses [$];
  coef_mat_t expected_matrices [$];
  pose_t     drv_pose;
  logic      req_taken = 1'b0;
  int        total_poses = 0;
  int        sent_cnt = 0;
  int        idle_cycles = 0;
  int        mismatch_cnt = 0;
  string     coef_name [9] = '{"row0_col0", "row0_col1", "row0_col2",
                               "row1_col0", "row1_col1", "row1_col2",
                               "row2_col0", "row2_col1", "row2_col2"};

  euler_to_rotation_matrix dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_roll_angle  (in_roll_angle),
    .in_pitch_angle (in_pitch_angle),
    .in_yaw_angle   (in_yaw_angle),
    .out_valid      (out_valid),
    .out_row0_col0  (out_row0_col0),
    .out_row0_col1  (out_row0_col1),
    .out_row0_col2  (out_row0_col2),
    .out_row1_col0  (out_row1_col0),
    .out_row1_col1  (out_row1_col1),
    .out_row1_col2  (out_row1_col2),
    .out_row2_col0  (out_row2_col0),
    .out_row2_col1  (out_row2_col1),
    .out_row2_col2  (out_row2_col2)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------- predictor
  function automatic longint angle_q30(input angle_t a);
    longint v;
    v = longint'(a) <<< (30 - (AW - 3));
    if (v > K_PI) begin
      v = K_PI;
    end else if (v < -K_PI) begin
      v = -K_PI;
    end
    return v;
  endfunction

  function automatic void sin_cos(input longint ang, output longint s, output longint c);
    longint x, y, z, dx, dy;
    bit     flip;
    x    = K_GAIN;
    y    = 64'sd0;
    flip = 1'b0;
    if (ang > K_HALF_PI) begin
      ang  = ang - K_PI;
      flip = 1'b1;
    end else if (ang < -K_HALF_PI) begin
      ang  = ang + K_PI;
      flip = 1'b1;
    end
    z = ang;
    for (int i = 0; i < erm_pkg::TRIG_STAGES && i < N_ATAN; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - CORDIC_ATAN[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + CORDIC_ATAN[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic longint mul_q30(input longint a, input longint b);
    return (a * b + (64'sd1 <<< 29)) >>> 30;
  endfunction

  // Q60 to Q1.14: round half up, floor shift, saturate at +-1
  function automatic coef_t to_coef(input longint v);
    longint r, lim;
    lim = 64'sd1 <<< FRAC_OUT;
    r   = (v + (64'sd1 <<< (59 - FRAC_OUT))) >>> (60 - FRAC_OUT);
    if (r > lim) begin
      r = lim;
    end else if (r < -lim) begin
      r = -lim;
    end
    return coef_t'(r[CW-1:0]);
  endfunction

  function automatic coef_mat_t rotation_of(input pose_t q);
    longint    sr, cr, sp, cp, sy, cy, sps, spc;
    coef_mat_t m;
    sin_cos(angle_q30(q.roll), sr, cr);
    sin_cos(angle_q30(q.pitch), sp, cp);
    sin_cos(angle_q30(q.yaw), sy, cy);
    sps  = mul_q30(sp, sr);
    spc  = mul_q30(sp, cr);
    m[0] = to_coef(cy * cp);
    m[1] = to_coef(cy * sps - sy * cr);
    m[2] = to_coef(cy * spc + sy * sr);
    m[3] = to_coef(sy * cp);
    m[4] = to_coef(sy * sps + cy * cr);
    m[5] = to_coef(sy * spc - cy * sr);
    m[6] = to_coef(-(sp <<< 30));
    m[7] = to_coef(cp * sr);
    m[8] = to_coef(cp * cr);
    return m;
  endfunction

  // ---------------------------------------------------------------- stimulus
  function automatic void push_pose(input int r, input int p, input int y);
    pose_t q;
    q.roll  = angle_t'(r);
    q.pitch = angle_t'(p);
    q.yaw   = angle_t'(y);
    pending_poses.push_back(q);
  endfunction

  // mostly legal angles; some raw patterns, near pi and pi/2, and tiny ones
  function automatic int rand_angle();
    int anchors [5];
    int v;
    anchors = '{0, A_HALF_LO, A_HALF_HI, A_PI - 1, A_PI};
    case ($urandom_range(0, 9))
      7: begin
        v = int'(angle_t'($urandom));
      end
      8: begin
        v = anchors[$urandom_range(0, 4)] + $urandom_range(0, 4) - 2;
        if ($urandom_range(0, 1)) begin
          v = -v;
        end
      end
      9: begin
        v = $urandom_range(0, 64) - 32;
      end
      default: begin
        v = $urandom_range(0, 2 * A_PI) - A_PI;
      end
    endcase
    return v;
  endfunction

  function automatic int gap_pct();
    if (sent_cnt < total_poses / 3) begin
      return 38;
    end else if (sent_cnt < 2 * total_poses / 3) begin
      return 53;
    end
    return 0;
  endfunction

  // ---------------------------------------------------------------- driver
  always @(negedge clk) begin
    if (rst_n && (!start || req_taken)) begin
      if (pending_poses.size() > 0 && $urandom_range(0, 99) >= gap_pct()) begin
        drv_pose = pending_poses.pop_front();
        in_roll_angle  <= drv_pose.roll;
        in_pitch_angle <= drv_pose.pitch;
        in_yaw_angle   <= drv_pose.yaw;
        start          <= 1'b1;
        sent_cnt++;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  always @(posedge clk) begin
    coef_mat_t got, want;
    pose_t     q;
    if (!rst_n) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= start && !busy;
      if (out_valid) begin
        got = {out_row2_col2, out_row2_col1, out_row2_col0,
               out_row1_col2, out_row1_col1, out_row1_col0,
               out_row0_col2, out_row0_col1, out_row0_col0};
        if (expected_matrices.size() == 0) begin
          $error("matrix result with no request outstanding");
          mismatch_cnt++;
        end else begin
          want = expected_matrices.pop_front();
          for (int k = 0; k < 9; k++) begin
            if (got[k] !== want[k]) begin
              $error("%s expected %0d actual %0d", coef_name[k],
                     $signed(want[k]), $signed(got[k]));
              mismatch_cnt++;
            end
          end
        end
      end
      if (start && !busy) begin
        q = {in_roll_angle, in_pitch_angle, in_yaw_angle};
        expected_matrices.push_back(rotation_of(q));
      end
      if (out_valid || (start && !busy)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin
    // zero, +-pi, raw extremes beyond pi, pi/2 fold boundary, gimbal lock
    push_pose(0, 0, 0);
    push_pose(A_PI, A_PI, A_PI);
    push_pose(-A_PI, -A_PI, -A_PI);
    push_pose(32767, -32768, 32767);
    push_pose(-32768, 32767, -32768);
    push_pose(A_PI - 1, 0, -(A_PI - 1));
    push_pose(A_HALF_HI, A_HALF_HI, A_HALF_HI);
    push_pose(A_HALF_LO, A_HALF_LO, -A_HALF_LO);
    push_pose(-A_HALF_HI, -A_HALF_HI, A_HALF_LO);
    push_pose(0, A_HALF_HI, 0);
    push_pose(0, -A_HALF_HI, 0);
    push_pose(A_HALF_LO, A_HALF_LO, 0);
    push_pose(1, -1, 1);
    push_pose(-1, 1, -1);
    push_pose(6434, -6434, 0);
    push_pose(8192, 8192, 8192);
    push_pose(-8192, 4096, -16384);
    push_pose(20000, -A_HALF_HI, 25000);
    repeat (N_POSES) begin
      push_pose(rand_angle(), rand_angle(), rand_angle());
    end
    total_poses = pending_poses.size();

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    do begin
      @(negedge clk);
    end while (pending_poses.size() != 0 || start || expected_matrices.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatch_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
